/* rtl/core/mirc_pkg.sv */
// ----------------------------------------------------------------------------
// mirc_pkg - shared types and constants for the Ising ring update block
// Command/status structs between controller and datapath, field widths, codes.
// ----------------------------------------------------------------------------
package mirc_pkg;

    localparam int SITE_W = 10;
    localparam int FRAC_W = 16;
    localparam int THR_W  = 17;
    localparam int DE_W   = 4;
    localparam int TOT_W  = 12;

    localparam logic [THR_W-1:0] THR_RST = 17'h10000;

    // item kinds carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TRIAL = 1'b1;

    // config register word index
    localparam logic REG_THR = 1'b0;

    // spin store read select
    localparam logic [1:0] SEL_LEFT  = 2'd0;
    localparam logic [1:0] SEL_CTR   = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;

    // energy step codes
    localparam logic [DE_W-1:0] DE_ZERO = 4'b0000;
    localparam logic [DE_W-1:0] DE_P4   = 4'b0100;
    localparam logic [DE_W-1:0] DE_M4   = 4'b1100;

    typedef struct packed {
        logic       load_item;
        logic [1:0] rd_sel;
        logic       cap_left;
        logic       cap_ctr;
        logic       clr_step;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_stat;

endpackage

/* rtl/core/mirc_ram.sv */
// ----------------------------------------------------------------------------
// mirc_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mirc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mirc_dp.sv */
// ----------------------------------------------------------------------------
// mirc_dp - datapath of the Ising ring update
// Item registers, neighbor capture, spin store, energy/magnetization totals.
// ----------------------------------------------------------------------------
module mirc_dp
    import mirc_pkg::*;
#(
    parameter int RING_SIZE = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_kind,
    input  logic [SITE_W-1:0]       i_site,
    input  logic                    i_spin_up,
    input  logic [FRAC_W-1:0]       i_frac,
    input  logic [THR_W-1:0]        i_thr,
    output logic                    o_accepted,
    output logic [DE_W-1:0]         o_energy_delta,
    output logic                    o_spin_now,
    output logic [TOT_W-1:0]        o_energy_total,
    output logic [TOT_W-1:0]        o_magnet_total
);

    localparam int               AW     = $clog2(RING_SIZE);
    localparam logic [16:0]      NUM_W  = 17'(RING_SIZE);
    localparam logic [AW-1:0]    LAST_A = AW'(RING_SIZE - 1);
    localparam logic [TOT_W-1:0] E_RST  = 12'((1 << 17) - RING_SIZE);
    localparam logic [TOT_W-1:0] M_RST  = 12'(RING_SIZE);

    // item
    logic              r_kind;
    logic              r_in_range;
    logic              r_up;
    logic [FRAC_W-1:0] r_frac;
    logic [AW-1:0]     r_ctr_addr;
    logic [AW-1:0]     r_left_addr;
    logic [AW-1:0]     r_right_addr;
    logic              r_left;
    logic              r_ctr;
    logic [AW-1:0]     r_clr_cnt;
    logic [TOT_W-1:0]  r_energy;
    logic [TOT_W-1:0]  r_magnet;
    logic              r_acc;
    logic [DE_W-1:0]   r_de;
    logic              r_spin;

    logic [16:0]       site17;
    logic [16:0]       left17;
    logic [16:0]       right17;
    logic              in_range;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic              ram_rdata;

    logic [DE_W-1:0]   de_v;
    logic              flip;
    logic [TOT_W-1:0]  dm_v;
    logic [TOT_W-1:0]  n_energy;
    logic [TOT_W-1:0]  n_magnet;

    // neighbor addresses with wrap-around
    assign site17   = {7'b0, i_site};
    assign in_range = site17 < NUM_W;
    assign left17   = (i_site == '0) ? NUM_W - 17'd1 : site17 - 17'd1;
    assign right17  = (site17 + 17'd1 >= NUM_W) ? 17'd0 : site17 + 17'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind       <= i_kind;
            r_in_range   <= in_range;
            r_up         <= i_spin_up;
            r_frac       <= i_frac;
            r_ctr_addr   <= in_range ? site17[AW-1:0]  : '0;
            r_left_addr  <= in_range ? left17[AW-1:0]  : '0;
            r_right_addr <= in_range ? right17[AW-1:0] : '0;
        end
        if (i_cmd.cap_left) begin
            r_left <= ram_rdata;
        end
        if (i_cmd.cap_ctr) begin
            r_ctr <= ram_rdata;
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            SEL_LEFT:  ram_raddr = r_left_addr;
            SEL_CTR:   ram_raddr = r_ctr_addr;
            SEL_RIGHT: ram_raddr = r_right_addr;
            default:   ram_raddr = r_ctr_addr;
        endcase
    end

    // dE = 2*s*(l+r); right neighbor is on the read port now
    always_comb begin
        if (r_left == ram_rdata) begin
            de_v = (r_ctr == r_left) ? DE_P4 : DE_M4;
        end else begin
            de_v = DE_ZERO;
        end
        if (!r_in_range) begin
            flip = 1'b0;
        end else if (r_kind == CMD_TRIAL) begin
            flip = (de_v != DE_P4) || ({1'b0, r_frac} < i_thr);
        end else begin
            flip = (r_ctr != r_up);
        end
        dm_v     = r_ctr ? 12'hFFE : 12'h002;
        n_energy = flip ? r_energy + {{(TOT_W-DE_W){de_v[DE_W-1]}}, de_v} : r_energy;
        n_magnet = flip ? r_magnet + dm_v : r_magnet;
    end

    assign ram_we    = i_cmd.clr_step || (i_cmd.commit && flip);
    assign ram_waddr = i_cmd.clr_step ? r_clr_cnt : r_ctr_addr;
    assign ram_wdata = i_cmd.clr_step ? 1'b1 : ~r_ctr;

    mirc_ram #(
        .WIDTH (1),
        .DEPTH (RING_SIZE)
    ) u_spins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_energy  <= E_RST;
            r_magnet  <= M_RST;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.commit) begin
                r_energy <= n_energy;
                r_magnet <= n_magnet;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_acc  <= flip;
            r_de   <= (r_in_range && (r_kind == CMD_TRIAL || flip)) ? de_v : DE_ZERO;
            r_spin <= r_in_range && (flip ? ~r_ctr : r_ctr);
        end
    end

    assign o_stat.clr_done = (r_clr_cnt == LAST_A);
    assign o_accepted      = r_acc;
    assign o_energy_delta  = r_de;
    assign o_spin_now      = r_spin;
    assign o_energy_total  = r_energy;
    assign o_magnet_total  = r_magnet;

endmodule

/* rtl/core/mirc_ctrl.sv */
// ----------------------------------------------------------------------------
// mirc_ctrl - controller of the Ising ring update
// Clear sweep, three neighbor reads, commit, result word valid.
// ----------------------------------------------------------------------------
module mirc_ctrl
    import mirc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RL   = 3'd2;
    localparam logic [2:0] S_RC   = 3'd3;
    localparam logic [2:0] S_RR   = 3'd4;
    localparam logic [2:0] S_EV   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = SEL_CTR;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_RL;
                end
            end
            S_RL: begin
                o_cmd.rd_sel = SEL_LEFT;
                n_state = S_RC;
            end
            S_RC: begin
                o_cmd.rd_sel   = SEL_CTR;
                o_cmd.cap_left = 1'b1;
                n_state = S_RR;
            end
            S_RR: begin
                o_cmd.rd_sel  = SEL_RIGHT;
                o_cmd.cap_ctr = 1'b1;
                n_state = S_EV;
            end
            S_EV: begin
                // keep right neighbor on the read port while stalled
                o_cmd.rd_sel = SEL_RIGHT;
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_m_tready))
        else $error("result word overwritten while pending");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_m_tvalid)
        else $error("commit did not raise result valid");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_RL))
        else $error("accepted word did not start neighbor reads");

    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && i_stat.clr_done) |=> o_s_tready)
        else $error("clear sweep did not end in idle");

endmodule

/* rtl/core/metropolis_ising_ring_update.sv */
// ----------------------------------------------------------------------------
// metropolis_ising_ring_update - Metropolis spin update on a 1-D Ising ring
// Flow: accept, then left, center and right reads through the one spin store
//   read port, then a commit that raises result word valid. A new word is taken
//   only after the last one commits (serial reads); a commit waits on a pending result.
// Reset: synchronous; spins are swept to +1 one site per cycle, input not
//   ready meanwhile; config writes are taken throughout.
// ----------------------------------------------------------------------------
module metropolis_ising_ring_update
    import mirc_pkg::*;
#(
    parameter int RING_SIZE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // site_index[9:0], spin_up[10], random_fraction[26:11]
    input  logic        s_axis_tuser,  // cmd: 0 load, 1 trial
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // accepted[0], energy_delta[4:1], spin_now[5],
                                       // energy_total[17:6], magnet_total[29:18]
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd             cmd;
    t_stat            stat;
    logic [THR_W-1:0] r_thr;
    logic             cfg_wr;

    logic             res_acc;
    logic [DE_W-1:0]  res_de;
    logic             res_spin;
    logic [TOT_W-1:0] res_energy;
    logic [TOT_W-1:0] res_magnet;

    // Threshold register: Q1.16 acceptance level for uphill flips.
    // 65536 and above accept every trial, 0 rejects every uphill one.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RST;
        end else if (cfg_wr) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_THR) ? {15'b0, r_thr} : 32'b0;

    // Controller sequences: clear sweep after reset, then per word
    // accept -> read left -> read center -> read right -> commit.
    mirc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Datapath holds the spin store, neighbor bits, dE/accept logic and the
    // running totals. Totals wrap modulo 2^12. Out-of-range sites change
    // nothing and report zero flags with the current totals.
    mirc_dp #(
        .RING_SIZE (RING_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (s_axis_tuser),
        .i_site         (s_axis_tdata[9:0]),
        .i_spin_up      (s_axis_tdata[10]),
        .i_frac         (s_axis_tdata[26:11]),
        .i_thr          (r_thr),
        .o_accepted     (res_acc),
        .o_energy_delta (res_de),
        .o_spin_now     (res_spin),
        .o_energy_total (res_energy),
        .o_magnet_total (res_magnet)
    );

    assign m_axis_tdata = {2'b00, res_magnet, res_energy, res_spin, res_de, res_acc};

endmodule
